### sv/htbd_pkg.sv
// Shared types and constants for the Huffman tree bit decoder.
// No dependencies; every other file in sv/ imports this package.
package htbd_pkg;

    localparam int          FC_W      = 10;          // first-child field width
    localparam int          CW        = FC_W + 1;    // child number incl. right step
    localparam logic [9:0]  SLOT_MAX  = 10'd1023;    // child counter saturation
    localparam logic [9:0]  SLOT_INIT = 10'd1;
    localparam logic [9:0]  SLOT_STEP = 10'd2;
    localparam int          TOP_BIT   = 7;
    localparam logic [3:0]  BYTE_BITS = 4'd8;
    localparam logic        REQ_LOAD  = 1'b0;
    localparam logic        REQ_CODE  = 1'b1;

    typedef struct packed {
        logic [7:0]      sym;
        logic            leaf;
        logic [FC_W-1:0] fc;
    } node_t;

    typedef struct packed {
        logic [7:0] sym;
        logic       bad;
        logic       last;
    } res_t;

endpackage

### sv/huffman_tree_bit_decoder_core.sv
// Huffman tree bit decoder, top level: node store, walker, output register.
// Depends on htbd_pkg, htbd_node_mem, htbd_walk and htbd_out_reg.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_stall  | req_type restart_tree node_symbol
//          |                    | node_is_leaf code_byte final_byte valid_bits
//  out     | out_valid/out_stall| symbol bad_code last_of_byte
//
// A load item is written to the node store as it is accepted; loads may
// follow each other every cycle while no code item is walked. A code item
// is walked to its end before the next accept: one dependent node-store read
// per code bit, one more step back to the root after each symbol found; a
// bit that hits a missing child needs no read.
// Reset clears the walk, the node count and the child counter; the node
// store itself is not cleared, entries beyond the node count are never read.
// in_stall is high while a code item is being walked; the walk also pauses
// while the output register is full and stalled.
module huffman_tree_bit_decoder_core
    import htbd_pkg::*;
#(
    parameter int MAX_NODES = 512
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       req_type,
    input  logic       restart_tree,
    input  logic [7:0] node_symbol,
    input  logic       node_is_leaf,
    input  logic [7:0] code_byte,
    input  logic       final_byte,
    input  logic [3:0] valid_bits,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] symbol,
    output logic       bad_code,
    output logic       last_of_byte
);

    localparam int AW  = $clog2(MAX_NODES);      // node address
    localparam int NLW = $clog2(MAX_NODES + 1);  // node count, holds MAX_NODES

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    node_t         wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    node_t         rd_data;
    logic          out_free;
    logic          push;
    res_t          push_item;

    // node store: symbol, leaf flag and first child per node
    htbd_node_mem #(
        .DEPTH (MAX_NODES),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // loads, child numbering and the per-bit tree walk
    htbd_walk #(
        .MAX_NODES (MAX_NODES),
        .AW        (AW),
        .NLW       (NLW)
    ) u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .restart_tree (restart_tree),
        .node_symbol  (node_symbol),
        .node_is_leaf (node_is_leaf),
        .code_byte    (code_byte),
        .final_byte   (final_byte),
        .valid_bits   (valid_bits),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .out_free     (out_free),
        .push         (push),
        .push_item    (push_item)
    );

    // result items wait here so the walk can keep going
    htbd_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_item    (push_item),
        .free         (out_free),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .symbol       (symbol),
        .bad_code     (bad_code),
        .last_of_byte (last_of_byte)
    );

endmodule

### sv/htbd_node_mem.sv
// Node store: one write port, one registered read port.
// Depends on htbd_pkg (node_t).
module htbd_node_mem
    import htbd_pkg::*;
#(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  node_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output node_t         rd_data
);

    node_t mem [DEPTH];
    node_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/htbd_out_reg.sv
// Output register for result items; reports when it can take a new one.
// Depends on htbd_pkg (res_t).
module htbd_out_reg
    import htbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  res_t       push_item,
    output logic       free,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] symbol,
    output logic       bad_code,
    output logic       last_of_byte
);

    logic valid_reg;
    res_t item_reg;

    assign free = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_reg <= push_item;
        end
    end

    assign out_valid    = valid_reg;
    assign symbol       = item_reg.sym;
    assign bad_code     = item_reg.bad;
    assign last_of_byte = item_reg.last;

endmodule

### sv/htbd_walk.sv
// Tree loader and bit walker: drives the node store, holds the walk
// position and the child counter, stages results. Depends on htbd_pkg.
module htbd_walk
    import htbd_pkg::*;
#(
    parameter int MAX_NODES = 512,
    parameter int AW        = 9,
    parameter int NLW       = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          req_type,
    input  logic          restart_tree,
    input  logic [7:0]    node_symbol,
    input  logic          node_is_leaf,
    input  logic [7:0]    code_byte,
    input  logic          final_byte,
    input  logic [3:0]    valid_bits,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output node_t         wr_data,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  node_t         rd_data,
    input  logic          out_free,
    output logic          push,
    output res_t          push_item
);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t          state_reg;
    logic [NLW-1:0]  nl_reg;
    logic [9:0]      slot_reg;
    logic            root_leaf_reg;
    logic [FC_W-1:0] root_fc_reg;
    logic            at_root_reg;
    logic            cur_leaf_reg;
    logic [FC_W-1:0] cur_fc_reg;
    logic            pend_reg;
    logic [7:0]      code_reg;
    logic [3:0]      left_reg;
    logic            fin_reg;
    logic            stg_valid_reg;
    logic [7:0]      stg_sym_reg;
    logic            stg_bad_reg;

    logic            accept;
    logic            ld_go;
    logic            ld_plain;
    logic [10:0]     slot_sum;
    logic [9:0]      slot_adv;
    logic            d_term;
    logic            base_leaf;
    logic [FC_W-1:0] base_fc;
    logic            go;
    logic            finish;
    logic            start;
    logic [CW-1:0]   child;
    logic            start_err;
    logic            new_res;
    logic [3:0]      nbits;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign ld_go    = accept && (req_type == REQ_LOAD);
    assign ld_plain = !restart_tree && (nl_reg < NLW'(MAX_NODES));

    // saturating child counter advance
    assign slot_sum = {1'b0, slot_reg} + {1'b0, SLOT_STEP};
    assign slot_adv = slot_sum[10] ? SLOT_MAX : slot_sum[9:0];

    always_comb
    begin
        wr_data.sym  = node_symbol;
        wr_data.leaf = node_is_leaf;
        if (node_is_leaf)
        begin
            wr_data.fc = '0;
        end
        else if (restart_tree)
        begin
            wr_data.fc = SLOT_INIT;
        end
        else
        begin
            wr_data.fc = slot_reg;
        end
    end

    assign wr_en   = ld_go && (restart_tree || ld_plain);
    assign wr_addr = restart_tree ? '0 : nl_reg[AW-1:0];

    assign nbits = (final_byte && valid_bits >= 4'd1 && valid_bits <= BYTE_BITS)
                   ? valid_bits : BYTE_BITS;

    // fetched child: a leaf, or an inner node whose left child is missing
    assign d_term = rd_data.leaf || (CW'(rd_data.fc) >= CW'(nl_reg));

    always_comb
    begin
        if (pend_reg)
        begin
            base_leaf = rd_data.leaf;
            base_fc   = rd_data.fc;
        end
        else if (at_root_reg)
        begin
            base_leaf = root_leaf_reg;
            base_fc   = root_fc_reg;
        end
        else
        begin
            base_leaf = cur_leaf_reg;
            base_fc   = cur_fc_reg;
        end
    end

    assign go        = (state_reg == ST_RUN) && out_free;
    assign finish    = !pend_reg && (left_reg == 4'd0);
    assign start     = (left_reg != 4'd0) && !(pend_reg && d_term);
    assign child     = CW'(base_fc) + CW'(code_reg[TOP_BIT]);
    assign start_err = base_leaf || (child >= CW'(nl_reg));
    assign new_res   = (pend_reg && d_term) || (start && start_err);

    assign rd_en   = go && start && !start_err;
    assign rd_addr = child[AW-1:0];

    // staged result goes out when the next one shows up or the byte ends
    assign push           = go && stg_valid_reg && (finish || new_res);
    assign push_item.sym  = stg_sym_reg;
    assign push_item.bad  = stg_bad_reg;
    assign push_item.last = finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            nl_reg        <= '0;
            slot_reg      <= SLOT_INIT;
            root_leaf_reg <= 1'b0;
            root_fc_reg   <= '0;
            at_root_reg   <= 1'b1;
            pend_reg      <= 1'b0;
            left_reg      <= '0;
            fin_reg       <= 1'b0;
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (ld_go)
                    begin
                        if (restart_tree)
                        begin
                            nl_reg        <= NLW'(1);
                            slot_reg      <= node_is_leaf ? SLOT_INIT : (SLOT_INIT + SLOT_STEP);
                            root_leaf_reg <= wr_data.leaf;
                            root_fc_reg   <= wr_data.fc;
                            at_root_reg   <= 1'b1;
                        end
                        else if (ld_plain)
                        begin
                            nl_reg <= nl_reg + NLW'(1);
                            if (!node_is_leaf)
                            begin
                                slot_reg <= slot_adv;
                            end
                            if (nl_reg == '0)
                            begin
                                root_leaf_reg <= wr_data.leaf;
                                root_fc_reg   <= wr_data.fc;
                            end
                        end
                    end
                    else if (accept)
                    begin
                        left_reg  <= nbits;
                        fin_reg   <= final_byte;
                        pend_reg  <= 1'b0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (go)
                    begin
                        if (finish)
                        begin
                            stg_valid_reg <= 1'b0;
                            if (fin_reg)
                            begin
                                at_root_reg <= 1'b1;
                            end
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            if (new_res)
                            begin
                                stg_valid_reg <= 1'b1;
                            end
                            if (pend_reg && !d_term && !(start && start_err))
                            begin
                                at_root_reg <= 1'b0;
                            end
                            if (pend_reg && d_term)
                            begin
                                at_root_reg <= 1'b1;
                                pend_reg    <= 1'b0;
                            end
                            else if (start)
                            begin
                                left_reg <= left_reg - 4'd1;
                                if (start_err)
                                begin
                                    at_root_reg <= 1'b1;
                                    pend_reg    <= 1'b0;
                                end
                                else
                                begin
                                    pend_reg <= 1'b1;
                                end
                            end
                            else
                            begin
                                pend_reg <= 1'b0;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && req_type == REQ_CODE)
        begin
            code_reg <= code_byte;
        end
        else if (go && !finish && !(pend_reg && d_term) && start)
        begin
            code_reg <= {code_reg[TOP_BIT-1:0], 1'b0};
        end
        if (go && !finish && pend_reg && !d_term)
        begin
            cur_leaf_reg <= rd_data.leaf;
            cur_fc_reg   <= rd_data.fc;
        end
        if (go && !finish && new_res)
        begin
            stg_sym_reg <= (pend_reg && d_term) ? rd_data.sym : 8'd0;
            stg_bad_reg <= !(pend_reg && d_term);
        end
    end

endmodule

### tb/sv/huffman_tree_bit_decoder_core_tb.sv
// Self-checking testbench for huffman_tree_bit_decoder_core: directed table,
// then random tree and code traffic, checked by a built-in tree-walk predictor.
// Depends on htbd_pkg and the core RTL.
`timescale 1ns / 1ps

module huffman_tree_bit_decoder_core_tb;
    import htbd_pkg::*;

    localparam int TREE_CAP     = 512;   // node store depth, also the DUT parameter
    localparam int TOTAL_ITEMS  = 370;   // directed rows plus random traffic
    localparam int LONG_HOLD    = 300;   // receiver hold-off, cycles
    localparam int DRAIN_CYCLES = 40;    // covers one code item still walking, with margin
    // Longest correct stretch with no handshake on either side is the long hold-off
    // (LONG_HOLD); everything else is far shorter.
    localparam int WDOG_LIMIT   = 4000;

    typedef struct packed {
        logic       req;
        logic       restart;
        logic [7:0] sym;
        logic       leaf;
        logic [7:0] code;
        logic       fin;
        logic [3:0] vb;
    } dec_item_t;

    // Directed row: item plus an optional hand-written expectation
    // (n copies of one result, last_of_byte on the final copy).
    typedef struct packed {
        dec_item_t  item;
        logic       typed;
        logic [3:0] n;
        logic [7:0] sym;
        logic       bad;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       req_type;
    logic       restart_tree;
    logic [7:0] node_symbol;
    logic       node_is_leaf;
    logic [7:0] code_byte;
    logic       final_byte;
    logic [3:0] valid_bits;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] symbol;
    logic       bad_code;
    logic       last_of_byte;

    // Predictor state: a private copy of the code-tree store and walk.
    logic [7:0]      tm_sym  [TREE_CAP];
    logic            tm_leaf [TREE_CAP];
    logic [FC_W-1:0] tm_fc   [TREE_CAP];
    int              tm_count;
    int              tm_slot;
    int              tm_walk;

    res_t     byte_res [8];       // results of the item just accepted
    int       byte_res_n;
    res_t     symbol_q [$];       // decoded results still owed by the DUT
    res_t     want_res;
    dir_row_t dir_rows [$];

    int items_sent;
    int fail_count;
    int idle_cycles;
    bit idle_on;
    bit hold_req;

    huffman_tree_bit_decoder_core #(
        .MAX_NODES(TREE_CAP)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .restart_tree (restart_tree),
        .node_symbol  (node_symbol),
        .node_is_leaf (node_is_leaf),
        .code_byte    (code_byte),
        .final_byte   (final_byte),
        .valid_bits   (valid_bits),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .symbol       (symbol),
        .bad_code     (bad_code),
        .last_of_byte (last_of_byte)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Inner nodes grab the next two child numbers; the counter saturates.
    function automatic void node_store(input int idx, input logic [7:0] s, input logic lf);
        tm_sym[idx]  = s;
        tm_leaf[idx] = lf;
        if (lf)
        begin
            tm_fc[idx] = '0;
        end
        else
        begin
            tm_fc[idx] = tm_slot[FC_W-1:0];
            tm_slot    = tm_slot + int'(SLOT_STEP);
            if (tm_slot > int'(SLOT_MAX))
                tm_slot = int'(SLOT_MAX);
        end
    endfunction

    function automatic void tree_load(input dec_item_t it);
        if (it.restart)
        begin
            tm_slot = int'(SLOT_INIT);
            node_store(0, it.sym, it.leaf);
            tm_count = 1;
            tm_walk  = 0;
        end
        else if (tm_count < TREE_CAP)
        begin
            node_store(tm_count, it.sym, it.leaf);
            tm_count++;
        end
        // store full: load dropped
    endfunction

    // Walk one code byte, MSB first; fills byte_res.
    function automatic void decode_byte(input dec_item_t it);
        int   nbits;
        int   cur;
        int   child;
        logic b;
        nbits = 8;
        if (it.fin && it.vb >= 4'd1 && it.vb <= BYTE_BITS)
            nbits = int'(it.vb);
        for (int i = 0; i < nbits; i++)
        begin
            b     = it.code[TOP_BIT - i];
            cur   = tm_walk;
            child = int'(tm_fc[cur]) + int'(b);
            if (tm_leaf[cur] || child >= tm_count || child >= TREE_CAP)
            begin
                // leaf as current node, or missing child: error, back to root
                byte_res[byte_res_n] = {8'h00, 1'b1, 1'b0};
                byte_res_n++;
                tm_walk = 0;
            end
            else if (tm_leaf[child] || int'(tm_fc[child]) >= tm_count)
            begin
                // flagged leaf, or inner node whose children never came
                byte_res[byte_res_n] = {tm_sym[child], 1'b0, 1'b0};
                byte_res_n++;
                tm_walk = 0;
            end
            else
            begin
                tm_walk = child;
            end
        end
        if (it.fin)
            tm_walk = 0;   // unfinished code dropped
        if (byte_res_n > 0)
            byte_res[byte_res_n - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Item construction: fields a request does not use stay random
    // ------------------------------------------------------------------

    function automatic dec_item_t any_item();
        dec_item_t it;
        it.req     = 1'($urandom_range(0, 1));
        it.restart = 1'($urandom_range(0, 1));
        it.sym     = 8'($urandom_range(0, 255));
        it.leaf    = 1'($urandom_range(0, 1));
        it.code    = 8'($urandom_range(0, 255));
        it.fin     = 1'($urandom_range(0, 1));
        it.vb      = 4'($urandom_range(0, 15));
        return it;
    endfunction

    function automatic dec_item_t load_item(input logic rs, input logic [7:0] s, input logic lf);
        dec_item_t it;
        it         = any_item();
        it.req     = REQ_LOAD;
        it.restart = rs;
        it.sym     = s;
        it.leaf    = lf;
        return it;
    endfunction

    // valid_bits only matters on a final byte; otherwise any value goes.
    function automatic dec_item_t code_item(input logic [7:0] c, input logic f, input logic [3:0] v);
        dec_item_t it;
        it      = any_item();
        it.req  = REQ_CODE;
        it.code = c;
        it.fin  = f;
        if (f)
            it.vb = v;
        return it;
    endfunction

    // n_typed < 0: expectation comes from the predictor
    function automatic void add_row(input dec_item_t it, input int n_typed,
                                    input logic [7:0] s, input logic b);
        dir_row_t row;
        row.item  = it;
        row.typed = (n_typed >= 0);
        row.n     = (n_typed >= 0) ? n_typed[3:0] : 4'd0;
        row.sym   = s;
        row.bad   = b;
        dir_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Sender: called at a falling edge, returns at a falling edge with
    // valid still high, so the next item can follow without a bubble.
    // ------------------------------------------------------------------
    task automatic send_item(input dec_item_t it, input bit typed, input int n_typed,
                             input logic [7:0] sym_typed, input logic bad_typed);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= it.req;
        restart_tree <= it.restart;
        node_symbol  <= it.sym;
        node_is_leaf <= it.leaf;
        code_byte    <= it.code;
        final_byte   <= it.fin;
        valid_bits   <= it.vb;
        do
            @(posedge clk);
        while (in_stall);
        // accepted at this edge
        byte_res_n = 0;
        if (it.req == REQ_LOAD)
            tree_load(it);
        else
            decode_byte(it);
        if (typed)
        begin
            for (int k = 0; k < n_typed; k++)
                symbol_q.push_back({sym_typed, bad_typed, k == n_typed - 1});
        end
        else
        begin
            for (int k = 0; k < byte_res_n; k++)
                symbol_q.push_back(byte_res[k]);
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send(input dec_item_t it);
        send_item(it, 1'b0, 0, 8'h00, 1'b0);
    endtask

    // Level-order full binary tree, root first. Stops after `cut` nodes,
    // which leaves a broken tree when cut is short.
    task automatic send_tree(input int size_cap, input int cut, input bit rs);
        int  pending;
        int  n;
        bit  inner;
        pending = 1;
        n       = 0;
        while (pending > 0 && n < cut)
        begin
            inner = (n + pending + 2 <= size_cap) && (n == 0 || $urandom_range(0, 9) < 6);
            send(load_item((n == 0) ? rs : 1'b0, 8'($urandom_range(0, 255)), !inner));
            pending = inner ? pending + 1 : pending - 1;
            n++;
        end
    endtask

    task automatic send_bytes(input int nbytes);
        logic f;
        for (int j = 0; j < nbytes; j++)
        begin
            f = (j == nbytes - 1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0);
            send(code_item(8'($urandom_range(0, 255)), f, 4'($urandom_range(1, 8))));
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off on request.
    // ------------------------------------------------------------------
    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each accepted result against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (symbol_q.size() == 0)
            begin
                $error("unexpected result: symbol %0h bad_code %0b last_of_byte %0b",
                       symbol, bad_code, last_of_byte);
                fail_count++;
            end
            else
            begin
                want_res = symbol_q.pop_front();
                if (symbol !== want_res.sym)
                begin
                    $error("symbol: expected %0h, actual %0h", want_res.sym, symbol);
                    fail_count++;
                end
                if (bad_code !== want_res.bad)
                begin
                    $error("bad_code: expected %0b, actual %0b", want_res.bad, bad_code);
                    fail_count++;
                end
                if (last_of_byte !== want_res.last)
                begin
                    $error("last_of_byte: expected %0b, actual %0b", want_res.last, last_of_byte);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("FAIL huffman_tree_bit_decoder_core");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int  kind;
        int  cap;
        bit  held;
        bit  paused;
        bit  force_long;

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        req_type     <= REQ_LOAD;
        restart_tree <= 1'b0;
        node_symbol  <= 8'h00;
        node_is_leaf <= 1'b0;
        code_byte    <= 8'h00;
        final_byte   <= 1'b0;
        valid_bits   <= 4'd0;
        fail_count  = 0;
        idle_cycles = 0;
        items_sent  = 0;
        idle_on     = 1'b1;
        hold_req    = 1'b0;
        held        = 1'b0;
        paused      = 1'b0;
        force_long  = 1'b0;
        tm_count    = 0;
        tm_slot     = int'(SLOT_INIT);
        tm_walk     = 0;

        // Directed table. The store is never walked before its first load,
        // since the node memory is not cleared by reset.
        add_row(load_item(1'b0, 8'hA5, 1'b1), 0, 8'h00, 1'b0);   // plain load into empty tree
        add_row(code_item(8'hFF, 1'b0, 4'd0), 8, 8'h00, 1'b1);   // root is a leaf: all errors
        add_row(code_item(8'h00, 1'b1, 4'd1), 1, 8'h00, 1'b1);
        add_row(load_item(1'b1, 8'h00, 1'b0), 0, 8'h00, 1'b0);   // restart, inner root
        add_row(code_item(8'h00, 1'b1, 4'd3), 3, 8'h00, 1'b1);   // children not loaded yet
        add_row(load_item(1'b0, 8'hFF, 1'b1), 0, 8'h00, 1'b0);   // left leaf
        add_row(code_item(8'h00, 1'b0, 4'd0), 8, 8'hFF, 1'b0);   // eight symbols from one byte
        add_row(code_item(8'h80, 1'b1, 4'd1), 1, 8'h00, 1'b1);   // missing right child
        add_row(load_item(1'b0, 8'h3C, 1'b0), 0, 8'h00, 1'b0);   // inner, its children absent
        add_row(code_item(8'hC0, 1'b1, 4'd2), 2, 8'h3C, 1'b0);   // childless inner acts as leaf
        add_row(load_item(1'b0, 8'h00, 1'b1), 0, 8'h00, 1'b0);
        add_row(code_item(8'hC0, 1'b0, 4'd0), -1, 8'h00, 1'b0);
        add_row(code_item(8'h80, 1'b0, 4'd0), -1, 8'h00, 1'b0);
        add_row(code_item(8'h01, 1'b0, 4'd0), -1, 8'h00, 1'b0);  // ends mid-walk
        add_row(code_item(8'h00, 1'b1, 4'd8), -1, 8'h00, 1'b0);  // walk carried across bytes
        add_row(code_item(8'h01, 1'b1, 4'd8), -1, 8'h00, 1'b0);  // unfinished code dropped
        add_row(code_item(8'h80, 1'b1, 4'd1), 0, 8'h00, 1'b0);   // byte with no result
        add_row(code_item(8'h01, 1'b0, 4'd0), -1, 8'h00, 1'b0);
        add_row(load_item(1'b0, 8'h77, 1'b1), 0, 8'h00, 1'b0);   // plain load keeps the walk
        add_row(code_item(8'h80, 1'b1, 4'd1), 1, 8'h77, 1'b0);
        add_row(code_item(8'h01, 1'b0, 4'd0), -1, 8'h00, 1'b0);
        add_row(load_item(1'b1, 8'h5A, 1'b1), 0, 8'h00, 1'b0);   // restart mid-walk
        add_row(code_item(8'h7F, 1'b1, 4'd1), 1, 8'h00, 1'b1);
        add_row(load_item(1'b1, 8'h11, 1'b0), 0, 8'h00, 1'b0);
        add_row(load_item(1'b0, 8'h22, 1'b1), 0, 8'h00, 1'b0);
        add_row(load_item(1'b0, 8'h33, 1'b1), 0, 8'h00, 1'b0);
        add_row(code_item(8'h5A, 1'b0, 4'd0), -1, 8'h00, 1'b0);
        add_row(code_item(8'hFF, 1'b1, 4'd8), 8, 8'h33, 1'b0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[r])
            send_item(dir_rows[r].item, dir_rows[r].typed, int'(dir_rows[r].n),
                      dir_rows[r].sym, dir_rows[r].bad);

        // Random episodes: mostly well-formed trees with random code bytes,
        // the rest broken trees and loose noise.
        while (items_sent < TOTAL_ITEMS)
        begin
            if (items_sent >= TOTAL_ITEMS * 85 / 100)
                idle_on = 1'b0;    // closing stretch runs flat out
            if (!held && items_sent >= 120)
            begin
                // receiver holds off while the sender keeps offering
                held       = 1'b1;
                hold_req   = 1'b1;
                force_long = 1'b1;
            end
            if (!paused && items_sent >= 250)
            begin
                // sender pauses until every owed result has come out
                paused = 1'b1;
                in_valid <= 1'b0;
                while (symbol_q.size() != 0)
                    @(posedge clk);
                @(negedge clk);
            end

            kind = force_long ? 0 : $urandom_range(0, 9);
            cap  = ($urandom_range(0, 7) == 0) ? $urandom_range(26, 90) : $urandom_range(1, 25);
            if (kind <= 6)
            begin
                send_tree(cap, TREE_CAP, 1'b1);
                send_bytes(force_long ? 8 : $urandom_range(2, 8));
                force_long = 1'b0;
            end
            else if (kind == 7)
            begin
                send_tree(cap, $urandom_range(1, cap), 1'($urandom_range(0, 1)));
                send_bytes($urandom_range(1, 5));
            end
            else
            begin
                repeat ($urandom_range(4, 10))
                begin
                    if ($urandom_range(0, 9) < 3)
                        send(load_item($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)),
                                       1'($urandom_range(0, 1))));
                    else
                        send(code_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                       4'($urandom_range(1, 8))));
                end
            end
        end

        in_valid <= 1'b0;
        while (symbol_q.size() != 0)
            @(posedge clk);
        // a code item can still be walking with nothing more to emit
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS huffman_tree_bit_decoder_core");
        else
            $display("FAIL huffman_tree_bit_decoder_core");
        $finish;
    end

endmodule
